// ===== rtl/cgs_pkg.sv =====
// cgs_pkg: shared constants, types and register codes of the circular smoother.
// Used by cgs_front, cgs_queue, cgs_back and circular_gaussian_smoother_unit.
// No dependencies.
package cgs_pkg;

	localparam int HALF_SPAN   = 6;
	localparam int DEPTH       = 2 * HALF_SPAN;
	localparam int SPAN        = DEPTH + 1;
	localparam int SAMPLE_W    = 16;
	localparam int COUNT_W     = 16;
	localparam int TAP_W       = 16;
	localparam int NUM_REGS    = 8;
	localparam int REG_IDX_W   = $clog2(NUM_REGS);
	localparam int SLOT_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int LINE_LEN    = 2 * DEPTH;
	localparam int PROD_W      = SAMPLE_W + TAP_W;
	localparam int GROUP_SIZE  = 4;
	localparam int GROUPS      = (SPAN + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PART_W      = PROD_W + $clog2(GROUP_SIZE);
	localparam int ACC_W       = PROD_W + $clog2(SPAN);
	localparam int FRAC_BITS   = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = COUNT_W'(401);

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_TAP0         = REG_IDX_W'(1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [HALF_SPAN:0][TAP_W-1:0] tap_vec_t;

	// one classified item on its way from front to back
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                head_we;
		logic [SLOT_W-1:0]   slot;
		logic                emit;
		logic                last;
		count_t              idx;
	} job_t;

	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} back_state_t;

endpackage

// ===== rtl/cgs_front.sv =====
// cgs_front: accepts height samples, tracks the position in the record and
// classifies each item (head store write, regular output, record end).
// Depends on cgs_pkg.
module cgs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cgs_pkg::sample_t       height_in,
	input  cgs_pkg::count_t        sample_count,
	input  logic                   q_full,
	output logic                   push,
	output cgs_pkg::job_t          job
);
	import cgs_pkg::*;

	count_t               count_q;
	count_t               n_eff;
	logic                 emit;
	logic                 last;
	logic [COUNT_W:0]     next_count;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// short records act as one full window
	assign n_eff      = (sample_count < COUNT_W'(SPAN)) ? COUNT_W'(SPAN) : sample_count;
	assign next_count = (COUNT_W + 1)'(count_q) + (COUNT_W + 1)'(1);
	assign emit       = count_q >= COUNT_W'(DEPTH);
	assign last       = emit && (next_count >= (COUNT_W + 1)'(n_eff));

	always_comb begin
		job.sample  = height_in;
		job.head_we = !emit;
		job.slot    = count_q[SLOT_W-1:0];
		job.emit    = emit;
		job.last    = last;
		job.idx     = count_q - COUNT_W'(HALF_SPAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= last ? '0 : next_count[COUNT_W-1:0];
		end
	end

endmodule

// ===== rtl/cgs_queue.sv =====
// cgs_queue: two-entry job queue between the front and the back end.
// Depends on cgs_pkg.
module cgs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cgs_pkg::job_t  push_job,
	output logic           full,
	output logic           valid,
	input  logic           pop,
	output cgs_pkg::job_t  head_job
);
	import cgs_pkg::*;

	job_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign head_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue popped while empty");
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("queue fill count did not follow a push");
`endif

endmodule

// ===== rtl/cgs_back.sv =====
// cgs_back: keeps the sample window and the head of the record, runs the
// 13-tap multiply/add pipeline and sequences the wrap-around flush.
// Depends on cgs_pkg.
module cgs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  cgs_pkg::job_t      job,
	output logic               job_pop,
	input  cgs_pkg::tap_vec_t  taps,
	output logic               out_valid,
	input  logic               out_ready,
	output cgs_pkg::count_t    sample_index,
	output cgs_pkg::sample_t   height_out,
	output logic               run_last
);
	import cgs_pkg::*;

	back_state_t         state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	count_t              idx_q;
	count_t              end_q;
	sample_t             win_q  [DEPTH];
	sample_t             head_q [DEPTH];
	sample_t             line_q [LINE_LEN];

	logic                adv;
	logic                issue;
	logic                use_line;
	logic                load_line;
	count_t              iss_idx;
	logic                iss_rl;
	sample_t             v_run  [SPAN];
	sample_t             v_iss  [SPAN];
	sample_t             s_full [LINE_LEN + 1];

	logic                      v_s1;
	logic signed [PROD_W-1:0]  prod_s1 [SPAN];
	count_t                    idx_s1;
	logic                      rl_s1;

	logic                      v_s2;
	logic signed [PART_W-1:0]  part_s2 [GROUPS];
	logic signed [PART_W-1:0]  part    [GROUPS];
	count_t                    idx_s2;
	logic                      rl_s2;

	logic signed [ACC_W-1:0]   acc;
	sample_t                   sat;

	logic                      out_valid_q;
	count_t                    out_idx_q;
	sample_t                   height_q;
	logic                      rl_q;

	// the whole pipeline moves when the output register is free or drains
	assign adv = !out_valid_q || out_ready;

	// window in sample order, oldest first; the incoming sample is the newest
	always_comb begin
		for (int q = 0; q < DEPTH; q++) begin
			v_run[q] = win_q[DEPTH - 1 - q];
		end
		v_run[DEPTH] = sample_t'(job.sample);
		// circle around the record end: last samples followed by the head
		for (int p = 0; p < SPAN; p++) begin
			s_full[p] = v_run[p];
		end
		for (int p = 0; p < DEPTH; p++) begin
			s_full[SPAN + p] = head_q[p];
		end
		for (int q = 0; q < SPAN; q++) begin
			v_iss[q] = use_line ? line_q[q] : v_run[q];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (job_valid && job.emit && job.last && adv) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (adv && cnt_q == CNT_W'(DEPTH)) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		issue     = 1'b0;
		use_line  = 1'b0;
		load_line = 1'b0;
		iss_idx   = job.idx;
		iss_rl    = !job.last;
		case (state_q)
			ST_RUN: begin
				// filling items only update the stores and never wait
				if (job_valid && (!job.emit || adv)) begin
					job_pop   = 1'b1;
					issue     = job.emit;
					load_line = job.emit && job.last;
				end
			end
			ST_FLUSH: begin
				issue    = adv;
				use_line = 1'b1;
				iss_idx  = idx_q;
				iss_rl   = cnt_q == CNT_W'(DEPTH);
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_line) begin
				cnt_q <= CNT_W'(1);
			end else if (state_q == ST_FLUSH && adv) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (adv) begin
				v_s1        <= issue;
				v_s2        <= v_s1;
				out_valid_q <= v_s2;
			end
		end
	end

	// sample stores and flush line
	always_ff @(posedge clk) begin
		if (job_pop) begin
			win_q[0] <= sample_t'(job.sample);
			for (int d = 1; d < DEPTH; d++) begin
				win_q[d] <= win_q[d - 1];
			end
			if (job.head_we) begin
				head_q[job.slot] <= sample_t'(job.sample);
			end
		end
		if (load_line) begin
			for (int p = 0; p < LINE_LEN; p++) begin
				line_q[p] <= s_full[p + 1];
			end
			idx_q <= job.idx + COUNT_W'(1);
			end_q <= job.idx + COUNT_W'(HALF_SPAN);
		end else if (state_q == ST_FLUSH && adv) begin
			for (int p = 0; p < LINE_LEN - 1; p++) begin
				line_q[p] <= line_q[p + 1];
			end
			idx_q <= (idx_q == end_q) ? '0 : idx_q + COUNT_W'(1);
		end
	end

	// grouped partial sums of the registered products
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			part[g] = '0;
		end
		for (int q = 0; q < SPAN; q++) begin
			part[q / GROUP_SIZE] = part[q / GROUP_SIZE] + PART_W'(prod_s1[q]);
		end
	end

	always_comb begin
		acc = '0;
		for (int g = 0; g < GROUPS; g++) begin
			acc = acc + ACC_W'(part_s2[g]);
		end
	end

	// floor shift, then clamp to the sample range
	always_comb begin
		if (acc[ACC_W-1:FRAC_BITS + SAMPLE_W - 1] == '0
				|| acc[ACC_W-1:FRAC_BITS + SAMPLE_W - 1] == '1) begin
			sat = acc[FRAC_BITS + SAMPLE_W - 1:FRAC_BITS];
		end else if (acc[ACC_W-1]) begin
			sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end
	end

	for (genvar q = 0; q < SPAN; q++) begin : g_mul
		localparam int TI = (q >= HALF_SPAN) ? q - HALF_SPAN : HALF_SPAN - q;
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s1[q] <= PROD_W'($signed(v_iss[q]) * $signed({1'b0, taps[TI]}));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1    <= iss_idx;
			rl_s1     <= iss_rl;
			part_s2   <= part;
			idx_s2    <= idx_s1;
			rl_s2     <= rl_s1;
			out_idx_q <= idx_s2;
			height_q  <= sat;
			rl_q      <= rl_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_index = out_idx_q;
	assign height_out   = height_q;
	assign run_last     = rl_q;

`ifndef SYNTHESIS
	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> (cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(DEPTH)))
		else $error("flush step count out of range");
	a_no_pop_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> !job_pop)
		else $error("job taken during flush");
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && adv && cnt_q == CNT_W'(DEPTH))
			|=> (state_q == ST_RUN && v_s1 && rl_s1))
		else $error("flush did not end on a final item");
`endif

endmodule

// ===== rtl/circular_gaussian_smoother_unit.sv =====
// Circular 13-tap smoother of a streamed height record: one height sample is
// taken per cycle while results drain; an item yields its result through the
// multiply, partial-sum and sum/saturate stages. The first twelve samples of
// a record give no result. The last sample of a record gives thirteen results,
// one per cycle while the output is not stalled, because the back end steps the
// wrap-around window through the single 13-multiplier datapath; meanwhile the
// two-entry job queue takes up to two further samples before input stalls.
// Top level: configuration registers, front, job queue and back end.
// Depends on cgs_pkg, cgs_front, cgs_queue and cgs_back.
module circular_gaussian_smoother_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [cgs_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [cgs_pkg::COUNT_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [cgs_pkg::SAMPLE_W-1:0] height_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cgs_pkg::COUNT_W-1:0]       sample_index,
	output logic signed [cgs_pkg::SAMPLE_W-1:0] height_out,
	output logic                              run_last
);
	import cgs_pkg::*;

	count_t    sample_count_q;
	tap_vec_t  taps_q;

	logic      push;
	job_t      push_job;
	logic      q_full;
	logic      q_valid;
	logic      q_pop;
	job_t      q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RESET;
			taps_q         <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_SAMPLE_COUNT) begin
				sample_count_q <= cfg_data;
			end else begin
				taps_q[cfg_index - REG_TAP0] <= cfg_data[TAP_W-1:0];
			end
		end
	end

	cgs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.height_in    (height_in),
		.sample_count (sample_count_q),
		.q_full       (q_full),
		.push         (push),
		.job          (push_job)
	);

	cgs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (q_pop),
		.head_job (q_job)
	);

	cgs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_valid),
		.job          (q_job),
		.job_pop      (q_pop),
		.taps         (taps_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_index (sample_index),
		.height_out   (height_out),
		.run_last     (run_last)
	);

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for circular_gaussian_smoother_unit, driven by plain tasks.
// A scoreboard class predicts every smoothed height and checks the output stream in order.
// Depends on cgs_pkg and the smoother RTL.
module tb_top;
	import cgs_pkg::*;

	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 80;
	localparam int ITEMS_PER_MIX = 115;
	localparam int SETTLE_CYCLES = 30;

	typedef enum {WAVE_NOISE, WAVE_RAMP, WAVE_CORNER} wave_t;
	typedef enum {TAPS_BELL, TAPS_RANDOM, TAPS_CORNER} tap_shape_t;

	class smooth_scoreboard;
		typedef struct {
			count_t  idx;
			sample_t height;
			bit      last;
		} smoothed_t;

		int        rec_len;
		int        tap_w[HALF_SPAN+1];
		sample_t   recent[DEPTH];
		sample_t   head[DEPTH];
		sample_t   window_now[DEPTH+1];
		int        arrived;
		smoothed_t pending[$];
		int        errors;
		int        checked;
		int        samples;
		int        records;

		function new();
			rec_len = int'(SAMPLE_COUNT_RESET);
			foreach (tap_w[t]) tap_w[t] = 0;
			foreach (recent[d]) begin
				recent[d] = '0;
				head[d]   = '0;
			end
			arrived = 0;
			errors  = 0;
			checked = 0;
			samples = 0;
			records = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
			if (idx == REG_SAMPLE_COUNT) begin
				rec_len = int'(val);
			end else begin
				tap_w[int'(idx) - int'(REG_TAP0)] = int'(val);
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		// sample j of the record, newest is the index of the sample just taken
		function sample_t fetch_sample(int j, int newest);
			if (j <= newest && newest - j <= DEPTH) return window_now[newest - j];
			if (j < DEPTH) return head[j];
			return '0;
		endfunction

		function sample_t smooth_at(int i, int len, int newest);
			longint acc;
			longint q;
			int     k;
			int     j;
			int     t;
			acc = 0;
			for (k = -HALF_SPAN; k <= HALF_SPAN; k++) begin
				t = (k < 0) ? -k : k;
				if (k < 0) begin
					j = (i >= -k) ? i + k : i + len + k;
				end else begin
					j = i + k;
					if (j >= len) j -= len;
				end
				acc += longint'(fetch_sample(j, newest)) * longint'(tap_w[t]);
			end
			q = acc >>> FRAC_BITS;
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			return sample_t'(q);
		endfunction

		function void push(int idx, sample_t h, bit last);
			smoothed_t e;
			e.idx    = count_t'(idx);
			e.height = h;
			e.last   = last;
			pending.push_back(e);
		endfunction

		function void note_sample(sample_t x);
			int a;
			int n;
			int len;
			int i;
			int idx;
			int m;
			int d;
			bit closing;
			a = arrived;
			n = (rec_len < SPAN) ? SPAN : rec_len;
			samples++;
			window_now[0] = x;
			for (d = 0; d < DEPTH; d++) window_now[d+1] = recent[d];
			if (a < DEPTH) head[a] = x;
			if (a >= DEPTH) begin
				closing = (a + 1 >= n);
				len     = closing ? a + 1 : n;
				i       = a - HALF_SPAN;
				push(i, smooth_at(i, len, a), !closing);
				if (closing) begin
					// wrap-around flush: tail of the record, then its head
					for (m = 1; m <= DEPTH; m++) begin
						idx = i + m;
						if (idx >= len) idx -= len;
						push(idx, smooth_at(idx, len, a), m == DEPTH);
					end
					records++;
				end
				arrived = closing ? 0 : a + 1;
			end else begin
				arrived = a + 1;
			end
			for (d = DEPTH - 1; d > 0; d--) recent[d] = recent[d-1];
			recent[0] = x;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_result(count_t idx, sample_t h, logic last);
			smoothed_t e;
			if (pending.size() == 0) begin
				report($sformatf("index %0d height %0d arrived with nothing expected", idx, h));
				return;
			end
			e = pending.pop_front();
			checked++;
			if (idx !== e.idx)
				report($sformatf("sample_index %0d, expected %0d", idx, e.idx));
			if (h !== e.height)
				report($sformatf("height_out %0d at index %0d, expected %0d", h, e.idx,
					e.height));
			if (last !== e.last)
				report($sformatf("run_last %b at index %0d, expected %b", last, e.idx,
					e.last));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [COUNT_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              height_in;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	count_t               sample_index;
	sample_t              height_out;
	logic                 run_last;

	logic    hold_off      = 1'b0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      items_sent    = 0;
	int      quiet         = 0;
	sample_t prev_height   = '0;

	sample_t corner_a[SPAN] = '{32767, 32767, 32767, 32767, 32767, 32767, 0, -1, 1,
		-32768, -32768, -32768, -32768};
	sample_t corner_b[SPAN] = '{-32768, 32767, 1, -1, 0, 16384, -16384, 21845, -21846,
		32767, 32767, -32768, -32768};

	smooth_scoreboard sb;

	circular_gaussian_smoother_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.height_in    (height_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_index (sample_index),
		.height_out   (height_out),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= arst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_sample(height_in);
			if (out_valid && out_ready) sb.check_result(sample_index, height_out, run_last);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles, %0d results outstanding",
					STALL_LIMIT, sb.outstanding());
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_taps(input tap_shape_t shape);
		int t;
		logic [TAP_W-1:0] w;
		w = TAP_W'($urandom_range(20000, 8000));
		for (t = 0; t <= HALF_SPAN; t++) begin
			case (shape)
			TAPS_RANDOM: w = TAP_W'($urandom);
			TAPS_CORNER: w = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: if (t > 0) w = TAP_W'(w * $urandom_range(95, 40) / 100);
			endcase
			write_reg(REG_IDX_W'(REG_TAP0 + t), w);
		end
	endtask

	// waits out the pipeline; filling samples leave nothing to wait for
	task automatic settle();
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_sample(input sample_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		height_in <= v;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	function automatic sample_t next_height(input wave_t wave, input sample_t prev);
		int d;
		case (wave)
		WAVE_RAMP: begin
			d = $urandom_range(2000);
			return sample_t'(prev + d - 1000);
		end
		WAVE_CORNER: begin
			case ($urandom_range(3))
			0: return sample_t'(32767);
			1: return sample_t'(-32768);
			2: return '0;
			default: return sample_t'($urandom);
			endcase
		end
		default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic stream(input int count, input wave_t wave);
		int k;
		for (k = 0; k < count; k++) begin
			prev_height = next_height(wave, prev_height);
			send_sample(prev_height);
		end
		in_valid <= 1'b0;
	endtask

	task automatic play_record(input int n_req, input bit cut, input wave_t wave,
		input bit squeeze);
		int k;
		settle();
		write_taps(tap_shape_t'($urandom_range(2)));
		if (cut) begin
			// long count, then shrink it mid-record so the next item closes the record
			write_reg(REG_SAMPLE_COUNT, COUNT_W'($urandom_range(65535, 200)));
			k = $urandom_range(30, SPAN);
			stream(k, wave);
			settle();
			write_reg(REG_SAMPLE_COUNT, COUNT_W'($urandom_range(k)));
			stream(1, wave);
		end else begin
			write_reg(REG_SAMPLE_COUNT, COUNT_W'(n_req));
			if (squeeze) begin
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			stream((n_req < SPAN) ? SPAN : n_req, wave);
		end
	endtask

	initial begin
		int mix;
		int t;
		int k;
		int n;
		sb = new();
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		height_in <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count below the minimum, three-tap saturating kernel, wrap over both extremes
		write_reg(REG_SAMPLE_COUNT, '0);
		for (t = 0; t <= HALF_SPAN; t++)
			write_reg(REG_IDX_W'(REG_TAP0 + t), (t < 2) ? 16'hFFFF : 16'h0000);
		for (k = 0; k < SPAN; k++) send_sample(corner_a[k]);
		in_valid <= 1'b0;
		settle();

		// longest count, then cut short so the flush wraps over what arrived
		write_reg(REG_SAMPLE_COUNT, '1);
		for (t = 0; t <= HALF_SPAN; t++)
			write_reg(REG_IDX_W'(REG_TAP0 + t), 16'hFFFF >> t);
		for (k = 0; k < SPAN; k++) send_sample(corner_b[k]);
		in_valid <= 1'b0;
		settle();
		write_reg(REG_SAMPLE_COUNT, COUNT_W'(1));
		send_sample(sample_t'(-32768));
		in_valid <= 1'b0;

		for (mix = 0; mix < 3; mix++) begin
			send_idle_pct = (mix == 0) ? 9 : (mix == 1) ? 84 : 0;
			recv_idle_pct = (mix == 0) ? 84 : (mix == 1) ? 9 : 0;
			if (mix == 2) play_record(40, 1'b0, WAVE_NOISE, 1'b1);
			while (items_sent < 2 * SPAN + 1 + ITEMS_PER_MIX * (mix + 1)) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(SPAN - 1) :
					$urandom_range(40, SPAN);
				play_record(n, $urandom_range(3) == 0, wave_t'($urandom_range(2)), 1'b0);
			end
		end
		settle();

		$display("run covered %0d samples in %0d records, %0d smoothed heights checked",
			sb.samples, sb.records, sb.checked);
		$display("counts from short to 65535, cut records, extreme taps, three idle mixes, one %0d-cycle output hold",
			HOLD_CYCLES);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cgs_pkg.sv
rtl/cgs_front.sv
rtl/cgs_queue.sv
rtl/cgs_back.sv
rtl/circular_gaussian_smoother_unit.sv
verif/tb_top.sv
